// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: property failed");

// Check that a condition is followed in the next cycle by another.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (conseq)) \
    else $error("%m: next-cycle property failed");

`endif

// File: rtl/core/rtq_pkg.sv
// ----------------------------------------------------------------------------
// rtq_pkg
// Types, codes and reset values of the retry transmit queue.
// ----------------------------------------------------------------------------
package rtq_pkg;

  // Default queue storage depth
  localparam int unsigned QUEUE_DEPTH_DEF = 32;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_SPACING    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_BACKOFF = 2'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [5:0]  QUEUE_LIMIT_RST   = 6'd30;
  localparam logic [3:0]  RETRY_LIMIT_RST   = 4'd5;
  localparam logic [15:0] TX_SPACING_RST    = 16'd5;
  localparam logic [15:0] RETRY_BACKOFF_RST = 16'd20;

  // Request types
  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_POLL    = 2'd1;
  localparam logic [1:0] REQ_OUTCOME = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_TX_REQ   = 3'd0;
  localparam logic [2:0] KIND_QUEUED   = 3'd1;
  localparam logic [2:0] KIND_DROPPED  = 3'd2;
  localparam logic [2:0] KIND_RETRY    = 3'd3;
  localparam logic [2:0] KIND_SENT     = 3'd4;
  localparam logic [2:0] KIND_GAVE_UP  = 3'd5;

  typedef struct packed {
    logic [5:0]  queue_limit;
    logic [3:0]  retry_limit;
    logic [15:0] tx_spacing;
    logic [15:0] retry_backoff;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [47:0] dest_addr;
    logic [15:0] payload_ref;
    logic [7:0]  payload_len;
    logic        send_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [47:0] out_addr;
    logic [15:0] out_payload_ref;
    logic [7:0]  out_payload_len;
    logic [3:0]  retries_left;
    logic [5:0]  queue_count;
  } res_t;

  // One queue entry as held in the entry memory
  typedef struct packed {
    logic [47:0] addr;
    logic [15:0] payload_ref;
    logic [7:0]  payload_len;
    logic [3:0]  budget;
    logic [31:0] due;
  } entry_t;

endpackage

// File: rtl/core/retry_transmit_queue.sv
// ----------------------------------------------------------------------------
// retry_transmit_queue
// Rate-limited transmit FIFO of frame descriptors with failure retry.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------------
//  request   | start / busy               | req_i (req_t)
//  result    | result_valid_o, one cycle  | result_o (res_t)
//  config    | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// On accept the request is registered and the head entry is read from the
// entry memory into a register. While busy, the request is acted on, any new
// tail entry is written and any result is registered; the result shows for
// exactly one cycle, during which the next request may be accepted.
// Reset clears pointers, fill, flight, last send, busy, result valid; not memory.
// The result receiver cannot stall.
`include "assert_macros.svh"

module retry_transmit_queue import rtq_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  result_valid_o,
  output res_t                  result_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

  cfg_t cfg;

  rtq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Entry memory and its registered read port
  entry_t mem_q [QueueDepth];
  entry_t rd_q;

  logic            exec_q;
  req_t            req_q;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [31:0]     last_send_q, last_send_d;
  logic            flight_q, flight_d;
  entry_t          flight_ent_q, flight_ent_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;

  logic            do_insert, do_pop, full;
  entry_t          ins_ent;
  logic [CntW-1:0] lim_eff;
  logic [31:0]     since_send;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  assign busy = exec_q;

  // Clamp the queue limit into 1..QueueDepth
  always_comb begin
    if (cfg.queue_limit == 6'd0) begin
      lim_eff = CntW'(1);
    end else if (32'(cfg.queue_limit) > 32'(QueueDepth)) begin
      lim_eff = CntW'(QueueDepth);
    end else begin
      lim_eff = CntW'(cfg.queue_limit);
    end
  end

  assign full       = (fill_q >= lim_eff) && (fill_q != '0);
  assign since_send = req_q.now_ms - last_send_q;

  // Act on the accepted request
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    fill_d       = fill_q;
    last_send_d  = last_send_q;
    flight_d     = flight_q;
    flight_ent_d = flight_ent_q;
    do_insert    = 1'b0;
    do_pop       = 1'b0;
    ins_ent      = rd_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;

    if (exec_q) begin
      case (req_q.req_type)
        REQ_ENQUEUE: begin
          do_insert           = 1'b1;
          ins_ent.addr        = req_q.dest_addr;
          ins_ent.payload_ref = req_q.payload_ref;
          ins_ent.payload_len = req_q.payload_len;
          ins_ent.budget      = cfg.retry_limit;
          ins_ent.due         = req_q.now_ms;
          res_valid_d         = 1'b1;
          res_d.result_kind   = full ? KIND_DROPPED : KIND_QUEUED;
          res_d.retries_left  = ins_ent.budget;
        end
        REQ_POLL: begin
          if (!flight_q && fill_q != '0 && since_send >= 32'(cfg.tx_spacing)
              && req_q.now_ms >= rd_q.due) begin
            do_pop             = 1'b1;
            flight_d           = 1'b1;
            flight_ent_d       = rd_q;
            ins_ent            = rd_q;
            res_valid_d        = 1'b1;
            res_d.result_kind  = KIND_TX_REQ;
            res_d.retries_left = rd_q.budget;
          end
        end
        REQ_OUTCOME: begin
          if (flight_q) begin
            flight_d    = 1'b0;
            last_send_d = req_q.now_ms;
            ins_ent     = flight_ent_q;
            res_valid_d = 1'b1;
            if (req_q.send_ok) begin
              res_d.result_kind  = KIND_SENT;
              res_d.retries_left = flight_ent_q.budget;
            end else if (flight_ent_q.budget > 4'd1) begin
              do_insert          = 1'b1;
              ins_ent.budget     = flight_ent_q.budget - 4'd1;
              ins_ent.due        = req_q.now_ms + 32'(cfg.retry_backoff);
              res_d.result_kind  = full ? KIND_DROPPED : KIND_RETRY;
              res_d.retries_left = ins_ent.budget;
            end else begin
              res_d.result_kind  = KIND_GAVE_UP;
              res_d.retries_left = 4'd0;
            end
          end
        end
        default: ;
      endcase

      // Advance pointers and fill count
      if (do_pop) begin
        head_d = ptr_next(head_q);
        fill_d = fill_q - CntW'(1);
      end
      if (do_insert) begin
        tail_d = ptr_next(tail_q);
        if (full) begin
          head_d = ptr_next(head_q);
        end else begin
          fill_d = fill_q + CntW'(1);
        end
      end

      res_d.out_addr        = ins_ent.addr;
      res_d.out_payload_ref = ins_ent.payload_ref;
      res_d.out_payload_len = ins_ent.payload_len;
      res_d.queue_count     = 6'(fill_d);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q      <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      last_send_q <= '0;
      flight_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      exec_q      <= start && !exec_q;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      last_send_q <= last_send_d;
      flight_q    <= flight_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start && !exec_q) begin
      req_q <= req_i;
    end
    flight_ent_q <= flight_ent_d;
    res_q        <= res_d;
  end

  // Entry memory: read head on accept, write tail on insert
  always_ff @(posedge clk_i) begin
    if (start && !exec_q) begin
      rd_q <= mem_q[head_q];
    end
    if (do_insert) begin
      mem_q[tail_q] <= ins_ent;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Checks
  `ASSERT_CLK(a_fill_bound, clk_i, rst_ni, fill_q <= CntW'(QueueDepth))
  `ASSERT_NEXT(a_busy_one_cycle, clk_i, rst_ni, busy, !busy)
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `ASSERT_CLK(a_tx_in_flight, clk_i, rst_ni,
              !(result_valid_o && result_o.result_kind == KIND_TX_REQ) || flight_q)
  `ASSERT_CLK(a_result_after_exec, clk_i, rst_ni, !result_valid_o || $past(exec_q))

endmodule

// File: rtl/core/rtq_cfg_regs.sv
// ----------------------------------------------------------------------------
// rtq_cfg_regs
// Configuration register file of the retry transmit queue.
// ----------------------------------------------------------------------------
module rtq_cfg_regs import rtq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Always take a write beat
  assign cfg_ready_o = 1'b1;

  // Update the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_QUEUE_LIMIT:   cfg_d.queue_limit   = cfg_data_i[5:0];
        CFG_RETRY_LIMIT:   cfg_d.retry_limit   = cfg_data_i[3:0];
        CFG_TX_SPACING:    cfg_d.tx_spacing    = cfg_data_i[15:0];
        CFG_RETRY_BACKOFF: cfg_d.retry_backoff = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.queue_limit   <= QUEUE_LIMIT_RST;
      cfg_q.retry_limit   <= RETRY_LIMIT_RST;
      cfg_q.tx_spacing    <= TX_SPACING_RST;
      cfg_q.retry_backoff <= RETRY_BACKOFF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
